FILE: src/wrp_pkg.sv
// Package for the WAV RIFF chunk parser: payload types, identifiers and codes.
`timescale 1ns / 1ps

package wrp_pkg;

   localparam int OFFSET_WIDTH_DEF = 32;

   // Identifiers as little-endian words assembled from the byte stream.
   localparam logic [31:0] ID_RIFF = 32'h4646_4952;
   localparam logic [31:0] ID_WAVE = 32'h4556_4157;
   localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
   localparam logic [31:0] ID_DATA = 32'h6174_6164;

   localparam logic [31:0] HDR_LEN       = 32'd12;
   localparam logic [31:0] CHUNK_HDR_LEN = 32'd8;
   localparam logic [31:0] FMT_MIN       = 32'd16;

   // Byte positions inside the RIFF header.
   localparam int POS_RIFF_ID   = 3;
   localparam int POS_RIFF_SIZE = 7;
   localparam int POS_WAVE_ID   = 11;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_SHORT     = 3'd1,
      STATUS_BAD_ID    = 3'd2,
      STATUS_CHUNK_OVR = 3'd3,
      STATUS_PAD_OVR   = 3'd4,
      STATUS_FMT_SMALL = 3'd5,
      STATUS_MISSING   = 3'd6
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] riff_size;
      logic [31:0] fmt_size;
      logic [15:0] audio_format;
      logic [15:0] channel_count;
      logic [31:0] sample_rate;
      logic [31:0] byte_rate;
      logic [15:0] block_align;
      logic [15:0] bits_per_sample;
      logic [31:0] data_size;
      logic [31:0] data_start;
   } rsp_type;

endpackage

FILE: src/wav_riff_chunk_parser.sv
// Top level of the WAV RIFF chunk parser: byte input, file length register, result output.
`timescale 1ns / 1ps
// A result is registered in the output buffer before it is visible on rsp_valid.
// Throughput: one byte per cycle; the whole parse step for a byte fits between the
// parse state registers, and a two-entry result stage absorbs output stalls.
// req_ready drops only when both result entries are full.
// Reset (synchronous, active high) clears file_length, the parse state and the results.

module wav_riff_chunk_parser #(
   parameter int OFFSET_WIDTH = wrp_pkg::OFFSET_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   // Configuration: the file length register.
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [31:0]      csr_wdata,
   // File bytes, one per transaction.
   input  logic             req_valid,
   output logic             req_ready,
   input  wrp_pkg::req_type req_data,
   // Parse results, at most one per file.
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output wrp_pkg::rsp_type rsp_data
);
   import wrp_pkg::*;

   logic    req_accept;
   logic    push_valid;
   logic    push_ready;
   rsp_type push_data;

   // The register takes a write in any cycle; it is up to the user that software writes it
   // only while the parser has no transaction in flight, as the block does not enforce it.
   assign csr_ready = 1'b1;

   // A byte may produce a result, so it is taken only when the result stage has room.
   assign req_ready  = push_ready;
   assign req_accept = req_valid && req_ready;

   // The parser checks the RIFF header, walks chunk headers by their sizes (with the
   // pad byte after odd sizes), captures the fmt fields and the data chunk location,
   // and reports once per file. After the report it skips bytes until is_last.
   wrp_parse #(
      .OFFSET_WIDTH(OFFSET_WIDTH)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_wdata  (csr_wdata),
      .req_accept (req_accept),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   // Results are registered here, so the output side never sees the parse logic.
   wrp_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: src/wrp_parse.sv
// Parser core: file length register, parse state and one-step byte evaluation.
`timescale 1ns / 1ps

module wrp_parse #(
   parameter int OFFSET_WIDTH = wrp_pkg::OFFSET_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   input  logic [31:0]      csr_wdata,
   input  logic             req_accept,
   input  wrp_pkg::req_type req_data,
   output logic             push_valid,
   output wrp_pkg::rsp_type push_data
);
   import wrp_pkg::*;

   typedef enum logic [3:0] {
      PH_HEADER  = 4'b0001,
      PH_CHUNK   = 4'b0010,
      PH_PAYLOAD = 4'b0100,
      PH_DONE    = 4'b1000
   } phase_type;

   logic [31:0]             flen_ff;
   phase_type               phase_ff, phase_in;
   logic [OFFSET_WIDTH-1:0] pos_ff, pos_in;
   logic [32:0]             left_ff, left_in;
   logic [31:0]             shift_ff, shift_in;
   logic [31:0]             cid_ff, cid_in;
   logic [4:0]              pofs_ff, pofs_in;
   logic                    fmt_seen_ff, fmt_seen_in;
   logic                    data_seen_ff, data_seen_in;
   logic [31:0]             riff_ff, riff_in;
   logic [31:0]             fmt_size_ff, fmt_size_in;
   logic [63:0]             fmt_lo_ff, fmt_lo_in;
   logic [63:0]             fmt_hi_ff, fmt_hi_in;
   logic [31:0]             dsize_ff, dsize_in;
   logic [OFFSET_WIDTH-1:0] dstart_ff, dstart_in;

   logic [31:0]             shift_n;
   logic [OFFSET_WIDTH-1:0] pos_inc;
   logic [32:0]             rem;
   logic [32:0]             left_dec;
   logic [32:0]             span;
   logic                    short_bnd;
   logic                    over_chunk;
   logic                    over_pad;
   logic                    in_fmt;
   logic                    emit;
   status_type              status;

   always_comb begin
      shift_n  = {req_data.data_byte, shift_ff[31:8]};
      pos_inc  = pos_ff + OFFSET_WIDTH'(1);
      // Bytes left in the file after the current one; bit 32 flags a position past the end.
      rem      = {1'b0, flen_ff} - 33'(pos_inc);
      short_bnd = rem[32] || (rem[31:0] < CHUNK_HDR_LEN);
      left_dec = left_ff - 33'd1;
      span     = {1'b0, shift_n} + 33'(shift_n[0]);
      over_chunk = rem[32] || ({1'b0, shift_n} > rem);
      over_pad   = span > rem;
      in_fmt   = (cid_ff == ID_FMT) && !pofs_ff[4];

      phase_in     = phase_ff;
      pos_in       = pos_ff;
      left_in      = left_ff;
      shift_in     = shift_ff;
      cid_in       = cid_ff;
      pofs_in      = pofs_ff;
      fmt_seen_in  = fmt_seen_ff;
      data_seen_in = data_seen_ff;
      riff_in      = riff_ff;
      fmt_size_in  = fmt_size_ff;
      fmt_lo_in    = fmt_lo_ff;
      fmt_hi_in    = fmt_hi_ff;
      dsize_in     = dsize_ff;
      dstart_in    = dstart_ff;
      emit         = 1'b0;
      status       = STATUS_OK;

      if (req_accept) begin
         case (phase_ff)
            PH_HEADER: begin
               shift_in = shift_n;
               if (pos_ff == '0 && flen_ff < HDR_LEN) begin
                  emit   = 1'b1;
                  status = STATUS_SHORT;
               end else if (pos_ff == OFFSET_WIDTH'(POS_RIFF_ID)) begin
                  cid_in = shift_n;
               end else if (pos_ff == OFFSET_WIDTH'(POS_RIFF_SIZE)) begin
                  riff_in = shift_n;
               end else if (pos_ff == OFFSET_WIDTH'(POS_WAVE_ID)) begin
                  if (cid_ff != ID_RIFF || shift_n != ID_WAVE) begin
                     emit   = 1'b1;
                     status = STATUS_BAD_ID;
                  end else if (flen_ff < HDR_LEN + CHUNK_HDR_LEN) begin
                     emit   = 1'b1;
                     status = STATUS_MISSING;
                  end else begin
                     phase_in = PH_CHUNK;
                     left_in  = 33'(CHUNK_HDR_LEN);
                  end
               end
            end
            PH_CHUNK: begin
               shift_in = shift_n;
               left_in  = left_dec;
               if (left_dec == 33'd4) begin
                  cid_in = shift_n;
               end
               if (left_dec == '0) begin
                  // Chunk header complete: shift_n holds the chunk size.
                  if (over_chunk) begin
                     emit   = 1'b1;
                     status = STATUS_CHUNK_OVR;
                  end else if (over_pad) begin
                     emit   = 1'b1;
                     status = STATUS_PAD_OVR;
                  end else if (cid_ff == ID_FMT && shift_n < FMT_MIN) begin
                     emit   = 1'b1;
                     status = STATUS_FMT_SMALL;
                  end else begin
                     if (cid_ff == ID_FMT) begin
                        fmt_size_in = shift_n;
                        fmt_seen_in = 1'b1;
                     end else if (cid_ff == ID_DATA) begin
                        dsize_in     = shift_n;
                        dstart_in    = pos_inc;
                        data_seen_in = 1'b1;
                     end
                     if (cid_ff == ID_DATA && fmt_seen_ff) begin
                        emit   = 1'b1;
                        status = STATUS_OK;
                     end else if (span == '0) begin
                        if (short_bnd) begin
                           emit   = 1'b1;
                           status = STATUS_MISSING;
                        end else begin
                           left_in = 33'(CHUNK_HDR_LEN);
                        end
                     end else begin
                        phase_in = PH_PAYLOAD;
                        left_in  = span;
                        pofs_in  = '0;
                     end
                  end
               end
            end
            PH_PAYLOAD: begin
               shift_in = shift_n;
               left_in  = left_dec;
               if (in_fmt) begin
                  for (int i = 0; i < 8; i++) begin
                     if (!pofs_ff[3] && pofs_ff[2:0] == 3'(i)) begin
                        fmt_lo_in[8*i +: 8] = req_data.data_byte;
                     end
                     if (pofs_ff[3] && pofs_ff[2:0] == 3'(i)) begin
                        fmt_hi_in[8*i +: 8] = req_data.data_byte;
                     end
                  end
                  pofs_in = pofs_ff + 5'd1;
               end
               if (in_fmt && pofs_ff[3:0] == 4'hF && data_seen_ff) begin
                  emit   = 1'b1;
                  status = STATUS_OK;
               end else if (left_dec == '0) begin
                  if (short_bnd) begin
                     emit   = 1'b1;
                     status = STATUS_MISSING;
                  end else begin
                     phase_in = PH_CHUNK;
                     left_in  = 33'(CHUNK_HDR_LEN);
                  end
               end
            end
            default: begin
            end
         endcase

         if (emit) begin
            phase_in = PH_DONE;
         end
         if (phase_in != PH_DONE) begin
            pos_in = pos_inc;
         end
         if (req_data.is_last && !emit && phase_ff != PH_DONE) begin
            emit   = 1'b1;
            status = STATUS_SHORT;
         end
      end

      // The result carries the fields as updated by this byte.
      push_valid                = emit;
      push_data.status          = status;
      push_data.riff_size       = riff_in;
      push_data.fmt_size        = fmt_size_in;
      push_data.audio_format    = fmt_lo_in[15:0];
      push_data.channel_count   = fmt_lo_in[31:16];
      push_data.sample_rate     = fmt_lo_in[63:32];
      push_data.byte_rate       = fmt_hi_in[31:0];
      push_data.block_align     = fmt_hi_in[47:32];
      push_data.bits_per_sample = fmt_hi_in[63:48];
      push_data.data_size       = dsize_in;
      push_data.data_start      = 32'(dstart_in);

      if (req_accept && req_data.is_last) begin
         phase_in     = PH_HEADER;
         pos_in       = '0;
         left_in      = '0;
         shift_in     = '0;
         cid_in       = '0;
         pofs_in      = '0;
         fmt_seen_in  = 1'b0;
         data_seen_in = 1'b0;
         riff_in      = '0;
         fmt_size_in  = '0;
         fmt_lo_in    = '0;
         fmt_hi_in    = '0;
         dsize_in     = '0;
         dstart_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flen_ff      <= '0;
         phase_ff     <= PH_HEADER;
         pos_ff       <= '0;
         left_ff      <= '0;
         shift_ff     <= '0;
         cid_ff       <= '0;
         pofs_ff      <= '0;
         fmt_seen_ff  <= 1'b0;
         data_seen_ff <= 1'b0;
         riff_ff      <= '0;
         fmt_size_ff  <= '0;
         fmt_lo_ff    <= '0;
         fmt_hi_ff    <= '0;
         dsize_ff     <= '0;
         dstart_ff    <= '0;
      end else begin
         if (csr_valid) begin
            flen_ff <= csr_wdata;
         end
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         left_ff      <= left_in;
         shift_ff     <= shift_in;
         cid_ff       <= cid_in;
         pofs_ff      <= pofs_in;
         fmt_seen_ff  <= fmt_seen_in;
         data_seen_ff <= data_seen_in;
         riff_ff      <= riff_in;
         fmt_size_ff  <= fmt_size_in;
         fmt_lo_ff    <= fmt_lo_in;
         fmt_hi_ff    <= fmt_hi_in;
         dsize_ff     <= dsize_in;
         dstart_ff    <= dstart_in;
      end
   end

endmodule

FILE: src/wrp_out_buf.sv
// Result register and a skid stage; input flows on in a stall until the skid fills.
`timescale 1ns / 1ps

module wrp_out_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  wrp_pkg::rsp_type push_data,
   output logic             push_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output wrp_pkg::rsp_type rsp_data
);
   import wrp_pkg::*;

   logic    main_valid_ff, main_valid_in;
   rsp_type main_data_ff, main_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    pop;
   logic    push;

   assign push_ready = !skid_valid_ff;
   assign pop        = main_valid_ff && rsp_ready;
   assign push       = push_valid && !skid_valid_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_valid_in = 1'b1;
            main_data_in  = push_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = push_data;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_data_ff;

endmodule

FILE: src/wrp_checker.sv
// Port-level checker for the WAV RIFF chunk parser and its bind statement.
`timescale 1ns / 1ps

module wrp_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input wrp_pkg::rsp_type rsp_data
);
   import wrp_pkg::*;

   // A stalled result keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // No result is pending right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Input back-pressure only happens while a result is waiting.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> rsp_valid)
      else $error("input stalled with no result pending");

   // Status codes stay within the defined set.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= STATUS_MISSING)
      else $error("undefined status code");

   // A successful parse always saw a fmt chunk of at least the minimum size.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_OK |-> rsp_data.fmt_size >= FMT_MIN)
      else $error("ok result with short fmt chunk");

endmodule

bind wav_riff_chunk_parser wrp_checker u_wrp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

FILE: tb/tb_wav_riff_chunk_parser.sv
// Self-checking testbench for the WAV RIFF chunk parser: directed and random files.
`timescale 1ns / 1ps

// The testbench feeds whole WAV files into the parser one byte per transaction and
// predicts the header result of every file in a scoreboard object. The prediction
// walks the same RIFF structure as the block: the twelve byte RIFF/WAVE header, then
// chunk headers with little-endian sizes, odd sizes padded by one byte, the first
// sixteen payload bytes of each fmt chunk captured, and the size and payload offset
// of the data chunk recorded. Each file yields exactly one result, either when the
// parse reaches a verdict or at the byte flagged as the last one.
//
// The file length register is written only while the parser is idle, which means
// after every expected result has been seen and a few extra cycles have passed. Files
// that share one length setting are sent back to back, so the result stage can fill
// while the receiver holds off.
module tb_wav_riff_chunk_parser;
   import wrp_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int RANDOM_BYTES    = 1100;
   localparam int HOLD_CYCLES     = 300;
   localparam int MAX_PRINTED     = 50;
   localparam int SQUEEZE_LENGTH  = 9;
   localparam logic [63:0] POS_MASK = 64'hFFFF_FFFF;
   localparam logic [31:0] ID_JUNK  = 32'h4B4E_554A;

   // Where the parse stands inside the current file.
   typedef enum logic [1:0] {
      WALK_RIFF_HDR,
      WALK_CHUNK_HDR,
      WALK_PAYLOAD,
      WALK_DONE
   } walk_phase_type;

   // Header scoreboard: tracks the parse of the current file and holds the results
   // that the block still owes.
   class wav_header_scoreboard;
      bit [31:0]      length_reg;
      walk_phase_type walk;
      bit [63:0]      position;
      bit [63:0]      left_in_chunk;
      bit [31:0]      shift_word;
      bit [31:0]      chunk_id;
      bit [31:0]      chunk_size;
      bit [31:0]      riff_size;
      bit [31:0]      fmt_size;
      bit [31:0]      data_size;
      bit [31:0]      data_start;
      bit [7:0]       fmt_bytes[16];
      bit             fmt_found;
      bit             data_found;
      bit             verdict_given;
      rsp_type        expected_headers[$];
      int             mismatches;
      int             results_checked;
      int             bytes_parsed;
      int             outcome_count[8];

      function new();
         length_reg = '0;
         mismatches = 0;
         results_checked = 0;
         bytes_parsed = 0;
         foreach (outcome_count[i]) outcome_count[i] = 0;
         restart_file();
      endfunction

      function void restart_file();
         walk = WALK_RIFF_HDR;
         position = '0;
         left_in_chunk = '0;
         shift_word = '0;
         chunk_id = '0;
         chunk_size = '0;
         riff_size = '0;
         fmt_size = '0;
         data_size = '0;
         data_start = '0;
         foreach (fmt_bytes[i]) fmt_bytes[i] = '0;
         fmt_found = 1'b0;
         data_found = 1'b0;
         verdict_given = 1'b0;
      endfunction

      function void set_length(bit [31:0] value);
         length_reg = value;
      endfunction

      // Fields that were never captured in this file are still zero here.
      function void give_verdict(status_type code);
         rsp_type hdr;
         hdr.status          = code;
         hdr.riff_size       = riff_size;
         hdr.fmt_size        = fmt_size;
         hdr.audio_format    = {fmt_bytes[1], fmt_bytes[0]};
         hdr.channel_count   = {fmt_bytes[3], fmt_bytes[2]};
         hdr.sample_rate     = {fmt_bytes[7], fmt_bytes[6], fmt_bytes[5], fmt_bytes[4]};
         hdr.byte_rate       = {fmt_bytes[11], fmt_bytes[10], fmt_bytes[9], fmt_bytes[8]};
         hdr.block_align     = {fmt_bytes[13], fmt_bytes[12]};
         hdr.bits_per_sample = {fmt_bytes[15], fmt_bytes[14]};
         hdr.data_size       = data_size;
         hdr.data_start      = data_start;
         expected_headers.push_back(hdr);
         outcome_count[code]++;
         walk = WALK_DONE;
         verdict_given = 1'b1;
      endfunction

      // A new chunk would start at offset next_ofs; it needs room for its header.
      function void next_chunk(bit [63:0] next_ofs);
         if (next_ofs + CHUNK_HDR_LEN > {32'd0, length_reg}) begin
            give_verdict(STATUS_MISSING);
         end else begin
            walk = WALK_CHUNK_HDR;
            left_in_chunk = CHUNK_HDR_LEN;
         end
      endfunction

      // Advances the parse by one accepted byte.
      function void note_byte(req_type item);
         bit [63:0] flen;
         bit [63:0] data_off;
         bit [63:0] sz;
         bit [63:0] span;
         bit [63:0] ofs;
         bit        in_fmt;
         flen = {32'd0, length_reg};
         if (walk != WALK_DONE) begin
            bytes_parsed++;
            shift_word = {item.data_byte, shift_word[31:8]};
            case (walk)
               WALK_RIFF_HDR: begin
                  if (position == 0 && length_reg < HDR_LEN) begin
                     give_verdict(STATUS_SHORT);
                  end else if (position == POS_RIFF_ID) begin
                     chunk_id = shift_word;
                  end else if (position == POS_RIFF_SIZE) begin
                     riff_size = shift_word;
                  end else if (position == POS_WAVE_ID) begin
                     if (chunk_id != ID_RIFF || shift_word != ID_WAVE) begin
                        give_verdict(STATUS_BAD_ID);
                     end else begin
                        next_chunk({32'd0, HDR_LEN});
                     end
                  end
               end
               WALK_CHUNK_HDR: begin
                  left_in_chunk--;
                  if (left_in_chunk == 4) chunk_id = shift_word;
                  if (left_in_chunk == 0) begin
                     chunk_size = shift_word;
                     data_off = (position + 1) & POS_MASK;
                     sz = {32'd0, chunk_size};
                     span = sz + sz[0];
                     // The size checks run in a fixed order: the bare payload first,
                     // then the payload with its pad byte, then the fmt minimum.
                     if (data_off > flen || sz > flen - data_off) begin
                        give_verdict(STATUS_CHUNK_OVR);
                     end else if (data_off + span > flen) begin
                        give_verdict(STATUS_PAD_OVR);
                     end else if (chunk_id == ID_FMT && sz < FMT_MIN) begin
                        give_verdict(STATUS_FMT_SMALL);
                     end else begin
                        if (chunk_id == ID_FMT) begin
                           fmt_size = chunk_size;
                           fmt_found = 1'b1;
                        end else if (chunk_id == ID_DATA) begin
                           data_size = chunk_size;
                           data_start = data_off[31:0];
                           data_found = 1'b1;
                        end
                        if (chunk_id == ID_DATA && fmt_found) begin
                           give_verdict(STATUS_OK);
                        end else begin
                           left_in_chunk = span;
                           if (span == 0) begin
                              next_chunk(data_off);
                           end else begin
                              walk = WALK_PAYLOAD;
                           end
                        end
                     end
                  end
               end
               WALK_PAYLOAD: begin
                  sz = {32'd0, chunk_size};
                  ofs = sz + sz[0] - left_in_chunk;
                  in_fmt = (chunk_id == ID_FMT) && (ofs < 16);
                  if (in_fmt) fmt_bytes[ofs[3:0]] = item.data_byte;
                  left_in_chunk--;
                  // A data chunk seen earlier completes the header on the last
                  // captured fmt byte.
                  if (in_fmt && ofs == 15 && data_found) begin
                     give_verdict(STATUS_OK);
                  end else if (left_in_chunk == 0) begin
                     next_chunk((position + 1) & POS_MASK);
                  end
               end
               default: begin
               end
            endcase
            if (walk != WALK_DONE) position = (position + 1) & POS_MASK;
         end
         if (item.is_last) begin
            if (!verdict_given) give_verdict(STATUS_SHORT);
            restart_file();
         end
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         if (mismatches <= MAX_PRINTED) $display("%0t ns MISMATCH: %s", $time, msg);
      endtask

      task check_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want) begin
            report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
         end
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (expected_headers.size() == 0) begin
            report_mismatch($sformatf("result with status %0d arrived, none pending",
                                      got.status));
         end else begin
            want = expected_headers.pop_front();
            results_checked++;
            check_field("status", got.status, want.status);
            check_field("riff_size", got.riff_size, want.riff_size);
            check_field("fmt_size", got.fmt_size, want.fmt_size);
            check_field("audio_format", got.audio_format, want.audio_format);
            check_field("channel_count", got.channel_count, want.channel_count);
            check_field("sample_rate", got.sample_rate, want.sample_rate);
            check_field("byte_rate", got.byte_rate, want.byte_rate);
            check_field("block_align", got.block_align, want.block_align);
            check_field("bits_per_sample", got.bits_per_sample, want.bits_per_sample);
            check_field("data_size", got.data_size, want.data_size);
            check_field("data_start", got.data_start, want.data_start);
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;

   wav_header_scoreboard sb;

   // Idling controls, set per phase by the stimulus process.
   int tx_idle_pct = 0;
   int rx_stall_pct = 0;
   // The stimulus process asks for a long receiver hold-off by bumping the request
   // count; the receiver process counts the hold-off cycles on its own.
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;

   int cycle_count = 0;
   int files_sent = 0;
   int bytes_sent = 0;
   int lengths_written = 0;

   // Bytes of the file that is about to be sent.
   bit [7:0] file_bytes[$];

   wav_riff_chunk_parser u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Every transaction is observed at the edge where it completes. Inputs change
   // only through nonblocking assignments, so the values read here are the ones
   // the block sampled at this same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.set_length(csr_wdata);
         if (req_valid && req_ready) sb.note_byte(req_data);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
      end
   end

   // Receiver: random stalls at the phase rate, or a long hold-off on request.
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Run stopped after %0d cycles with %0d results outstanding", cycle_count,
               sb.expected_headers.size());
      $display("== FAIL ==");
      $finish;
   end

   function void put_word(bit [31:0] w);
      file_bytes.push_back(w[7:0]);
      file_bytes.push_back(w[15:8]);
      file_bytes.push_back(w[23:16]);
      file_bytes.push_back(w[31:24]);
   endfunction

   function void put_half(bit [15:0] h);
      file_bytes.push_back(h[7:0]);
      file_bytes.push_back(h[15:8]);
   endfunction

   function void put_random(int count);
      repeat (count) file_bytes.push_back(8'($urandom));
   endfunction

   function void start_file(bit [31:0] riff_id, bit [31:0] size, bit [31:0] wave_id);
      file_bytes.delete();
      put_word(riff_id);
      put_word(size);
      put_word(wave_id);
   endfunction

   // Pushes a chunk header and at most keep payload bytes. Returns 0 when the
   // payload had to be cut short; the caller then adds no more chunks.
   function bit put_chunk(bit [31:0] id, bit [31:0] size, int keep);
      bit [63:0] span;
      put_word(id);
      put_word(size);
      span = {32'd0, size} + size[0];
      if (span > keep) begin
         put_random(keep);
         return 1'b0;
      end
      put_random(int'(span));
      return 1'b1;
   endfunction

   // A fmt chunk with the given fields; bytes past the sixteenth are random.
   function void put_fmt(bit [31:0] size, bit [15:0] format, bit [15:0] channels,
                         bit [31:0] rate, bit [31:0] brate, bit [15:0] align,
                         bit [15:0] bits);
      put_word(ID_FMT);
      put_word(size);
      put_half(format);
      put_half(channels);
      put_word(rate);
      put_word(brate);
      put_half(align);
      put_half(bits);
      put_random(int'(size) + size[0] - 16);
   endfunction

   // Builds a mostly well-formed file for the given length setting: a valid header
   // with an occasional flipped bit, then a few chunks of random kind whose sizes
   // usually fit, sometimes fill the file exactly and sometimes overrun it.
   function void make_random_file(bit [31:0] flen);
      bit [63:0] offset;
      bit [63:0] rem;
      bit [31:0] id;
      bit [31:0] size;
      int        n_chunks;
      int        r;
      int        pick;
      int        cut;
      bit        whole;
      start_file(ID_RIFF, ($urandom_range(1) != 0) ? flen - 8 : $urandom, ID_WAVE);
      if ($urandom_range(19) == 0) begin
         pick = $urandom_range(7);
         if (pick > 3) pick += 4;
         file_bytes[pick] ^= 8'h01 << $urandom_range(7);
      end
      offset = 64'd12;
      n_chunks = $urandom_range(5, 1);
      whole = 1'b1;
      for (int k = 0; k < n_chunks && whole && offset + 8 <= {32'd0, flen}; k++) begin
         rem = {32'd0, flen} - offset - 8;
         r = $urandom_range(99);
         case ($urandom_range(2))
            0: begin
               id = ID_FMT;
               if (r < 80) size = $urandom_range(24, 16);
               else if (r < 90) size = $urandom_range(15, 0);
               else size = $urandom;
            end
            1: begin
               id = ID_DATA;
               if (r < 70) size = $urandom_range(30, 0);
               else if (r < 88) size = rem[31:0];
               else size = $urandom;
            end
            default: begin
               id = (r < 10) ? ID_FMT ^ (32'd1 << $urandom_range(31)) : $urandom;
               if (r < 75) size = $urandom_range(12, 0);
               else if (r < 90) size = rem[31:0] - $urandom_range(1);
               else size = $urandom;
            end
         endcase
         whole = put_chunk(id, size, 24);
         offset += 64'd8 + size + size[0];
      end
      put_random($urandom_range(4));
      // Now and then the file ends early.
      if ($urandom_range(9) == 0) begin
         cut = $urandom_range(file_bytes.size() - 1, 1);
         while (file_bytes.size() > cut) void'(file_bytes.pop_back());
      end
   endfunction

   function bit [31:0] pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 5) return $urandom_range(11, 0);
      if (r < 10) return 32'hFFFF_FFFF;
      if (r < 15) return $urandom;
      if (r < 25) return $urandom_range(40, 12);
      return $urandom_range(240, 40);
   endfunction

   // One byte transaction; valid stays up after it so the next byte can follow
   // without a gap.
   task send_byte(bit [7:0] value, bit last);
      req_type item;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      item.data_byte = value;
      item.is_last = last;
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   task send_file();
      foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
      bytes_sent += file_bytes.size();
      files_sent++;
   endtask

   // The sender pauses until every pending result has arrived, then gives the
   // block a few more cycles to settle.
   task wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.expected_headers.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task write_length(bit [31:0] value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      lengths_written++;
   endtask

   task load_and_send(bit [31:0] flen);
      wait_for_results();
      write_length(flen);
      send_file();
   endtask

   task run_group(bit [31:0] flen, int n_files);
      make_random_file(flen);
      load_and_send(flen);
      repeat (n_files - 1) begin
         make_random_file(flen);
         send_file();
      end
   endtask

   // Short files stream in while the receiver holds off, so results pile up in
   // the block and it has to stall its input.
   task squeeze_output();
      wait_for_results();
      write_length(SQUEEZE_LENGTH);
      hold_requests++;
      repeat (12) begin
         file_bytes.delete();
         put_random(3);
         send_file();
      end
   endtask

   int tx_idle_by_phase[4] = '{0, 49, 0, 12};
   int rx_stall_by_phase[4] = '{0, 0, 49, 12};

   initial begin
      int phase_bytes;
      int phase_files;
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed files. A file length below the header size is short on the first
      // byte whatever follows.
      start_file(ID_RIFF, 32'd36, ID_WAVE);
      load_and_send(32'd0);
      load_and_send(32'd11);
      // Minimal complete files with the fmt fields at opposite extremes and an
      // empty data chunk; in the second one ignored bytes follow the result.
      put_fmt(32'd16, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h0000);
      put_word(ID_DATA);
      put_word(32'd0);
      load_and_send(32'd44);
      start_file(ID_RIFF, 32'hFFFF_FFFF, ID_WAVE);
      put_fmt(32'd16, 16'h0000, 16'hFFFF, 32'h0, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF);
      put_word(ID_DATA);
      put_word(32'd0);
      put_random(3);
      load_and_send(32'd44);
      // Wrong RIFF identifier, then wrong WAVE identifier.
      start_file(ID_RIFF ^ 32'h0100_0000, 32'd92, ID_WAVE);
      load_and_send(32'd100);
      start_file(ID_RIFF, 32'd92, ID_WAVE ^ 32'h8000_0000);
      load_and_send(32'd100);
      // No room for any chunk header after the RIFF header.
      start_file(ID_RIFF, 32'd4, ID_WAVE);
      load_and_send(32'd12);
      // Two empty chunks, the second ending exactly at the file length.
      start_file(ID_RIFF, 32'd20, ID_WAVE);
      void'(put_chunk(ID_JUNK, 32'd0, 0));
      void'(put_chunk(ID_JUNK, 32'd0, 0));
      load_and_send(32'd28);
      // A chunk larger than the rest of the file, with a normal and a maximal length.
      start_file(ID_RIFF, 32'd52, ID_WAVE);
      void'(put_chunk(ID_JUNK, 32'd1000, 2));
      load_and_send(32'd60);
      start_file(ID_RIFF, 32'hFFFF_FFF7, ID_WAVE);
      void'(put_chunk(ID_JUNK, 32'hFFFF_FFFF, 2));
      load_and_send(32'hFFFF_FFFF);
      // An odd chunk that fits but whose pad byte would not.
      start_file(ID_RIFF, 32'd23, ID_WAVE);
      void'(put_chunk(ID_JUNK, 32'd11, 2));
      load_and_send(32'd31);
      // A fmt chunk below the minimum size.
      start_file(ID_RIFF, 32'd92, ID_WAVE);
      void'(put_chunk(ID_FMT, 32'd15, 16));
      load_and_send(32'd100);
      // Data chunk with a pad byte before the fmt chunk: the result comes on the
      // last captured fmt byte.
      start_file(ID_RIFF, 32'hFFFF_FFF7, ID_WAVE);
      void'(put_chunk(ID_DATA, 32'd3, 4));
      put_fmt(32'd18, 16'd1, 16'd2, 32'd48000, 32'd192000, 16'd4, 16'd16);
      load_and_send(32'hFFFF_FFFF);
      // A second fmt chunk overwrites the first one.
      start_file(ID_RIFF, 32'd192, ID_WAVE);
      put_fmt(32'd16, 16'd1, 16'd2, 32'd3, 32'd4, 16'd5, 16'd6);
      put_fmt(32'd17, 16'd7, 16'd8, 32'd9, 32'd10, 16'd11, 16'd12);
      void'(put_chunk(ID_DATA, 32'd20, 2));
      load_and_send(32'd200);
      // Files that end early: inside the first chunk header and on the very first byte.
      start_file(ID_RIFF, 32'd92, ID_WAVE);
      put_random(3);
      load_and_send(32'd100);
      file_bytes.delete();
      put_random(1);
      load_and_send(32'd100);

      // Random files in four idling phases.
      for (int p = 0; p < 4; p++) begin
         tx_idle_pct = tx_idle_by_phase[p];
         rx_stall_pct = rx_stall_by_phase[p];
         phase_bytes = bytes_sent;
         phase_files = files_sent;
         if (p == 0) squeeze_output();
         while (bytes_sent - phase_bytes < RANDOM_BYTES / 4 ||
                files_sent - phase_files < 3) begin
            run_group(pick_length(), $urandom_range(3, 1));
         end
      end

      wait_for_results();
      repeat (8) @(posedge clock);

      $display("Covered %0d files (%0d bytes sent, %0d parsed) under %0d lengths; %0d checked.",
               files_sent, bytes_sent, sb.bytes_parsed, lengths_written,
               sb.results_checked);
      $display("Verdicts: ok %0d, short %0d, bad id %0d, overrun %0d, pad %0d, %0s %0d, %0s %0d",
               sb.outcome_count[STATUS_OK], sb.outcome_count[STATUS_SHORT],
               sb.outcome_count[STATUS_BAD_ID], sb.outcome_count[STATUS_CHUNK_OVR],
               sb.outcome_count[STATUS_PAD_OVR], "fmt", sb.outcome_count[STATUS_FMT_SMALL],
               "missing", sb.outcome_count[STATUS_MISSING]);
      if (sb.mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: files.f
src/wrp_pkg.sv
src/wrp_parse.sv
src/wrp_out_buf.sv
src/wav_riff_chunk_parser.sv
src/wrp_checker.sv
tb/tb_wav_riff_chunk_parser.sv
